@@ rtl/ibpd_pkg.sv @@
`default_nettype none

package ibpd_pkg;

  // Depth of the burst as the decoder sees it: positions 0 to 32.
  localparam int unsigned StoreDepth = 33;
  // Default number of positions counted in one burst before bytes are dropped.
  localparam int unsigned BurstCapacityDefault = 64;

  // Acceleration packet occupies positions 0 to 10, angle packet 22 to 32.
  localparam int unsigned PacketLen  = 11;
  localparam int unsigned AccelFirst = 0;
  localparam int unsigned AngleFirst = 22;

  localparam logic [7:0] StartByte = 8'h55;
  localparam logic [7:0] AccelType = 8'h51;
  localparam logic [7:0] AngleType = 8'h53;

  typedef enum logic [0:0] {
    OP_BYTE = 1'b0,
    OP_IDLE = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic        [15:0] yaw_angle;
    logic               accel_updated;
    logic               angle_updated;
  } out_word_t;

endpackage

`default_nettype wire

@@ rtl/imu_burst_packet_decoder_core.sv @@
`default_nettype none

// Channel | Direction | Handshake                  | Word
// --------+-----------+----------------------------+-------------------------------
// in      | input     | in_valid_i / in_ready_o    | in_word_i  (opcode, rx_byte)
// out     | output    | out_valid_o / out_ready_i  | out_word_o (held values, flags)
//
// One word is accepted per cycle unless an idle event waits in the input register.
// There a received byte is written to the burst store and an idle event is decoded.
// The result of an idle event is then loaded into the output register, from
// which it is handed over; bytes give no result.
// An idle event waits in the input register only while an earlier result is still
// untaken at the output register; a received byte is held up only when it queues
// behind such a waiting idle event.
// Reset clears the burst store, the write position and the held values to zero.

module imu_burst_packet_decoder_core
  import ibpd_pkg::*;
#(
  parameter int unsigned BurstCapacity = BurstCapacityDefault
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  in_word_t   in_word_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output out_word_t  out_word_o
);

  // The position counts up to and saturates at the burst capacity.
  localparam int unsigned PosW = $clog2(BurstCapacity + 1);
  localparam int unsigned IdxW = $clog2(PacketLen);

  localparam logic [PosW-1:0] CapPos        = PosW'(BurstCapacity);
  localparam logic [PosW-1:0] AccelEndPos   = PosW'(AccelFirst + PacketLen);
  localparam logic [PosW-1:0] AngleStartPos = PosW'(AngleFirst);
  localparam logic [PosW-1:0] AngleEndPos   = PosW'(AngleFirst + PacketLen);

  // Input register stage.
  logic     in_valid_q;
  in_word_t in_word_q;

  // Only the two packet windows of the burst are ever inspected, so only they are kept.
  logic [7:0] accel_store_q [PacketLen];
  logic [7:0] angle_store_q [PacketLen];
  logic [PosW-1:0] pos_q;

  logic [15:0] held_accel_q [3];
  logic [15:0] held_angle_q [3];
  logic        accel_upd_q;
  logic        angle_upd_q;
  logic        out_valid_q;

  logic proc_go;
  logic is_byte;
  logic is_idle;

  logic [7:0] accel_sum;
  logic [7:0] angle_sum;
  logic [7:0] accel_pair [5];
  logic [7:0] angle_pair [5];
  logic       accel_ok;
  logic       angle_ok;

  logic [IdxW-1:0] accel_idx;
  logic [IdxW-1:0] angle_idx;

  assign is_byte = (in_word_q.opcode == OP_BYTE);
  assign is_idle = (in_word_q.opcode == OP_IDLE);

  // A byte always moves on; an idle event needs the output register to be free
  // or being emptied in this cycle.
  assign proc_go    = in_valid_q && (is_byte || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc_go;

  // Checksums over ten bytes: pairs first, then the five pair sums.
  always_comb begin
    for (int k = 0; k < 5; k++) begin
      accel_pair[k] = accel_store_q[2 * k] + accel_store_q[2 * k + 1];
      angle_pair[k] = angle_store_q[2 * k] + angle_store_q[2 * k + 1];
    end
    accel_sum = (accel_pair[0] + accel_pair[1]) + (accel_pair[2] + accel_pair[3])
                + accel_pair[4];
    angle_sum = (angle_pair[0] + angle_pair[1]) + (angle_pair[2] + angle_pair[3])
                + angle_pair[4];
  end

  // Neither packet counts unless the burst opens with the start byte.
  assign accel_ok = (accel_store_q[0] == StartByte) &&
                    (accel_sum == accel_store_q[PacketLen - 1]) &&
                    (accel_store_q[1] == AccelType);
  assign angle_ok = (accel_store_q[0] == StartByte) &&
                    (angle_sum == angle_store_q[PacketLen - 1]) &&
                    (angle_store_q[1] == AngleType);

  assign accel_idx = pos_q[IdxW-1:0];
  assign angle_idx = IdxW'(pos_q - AngleStartPos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      in_word_q   <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      accel_upd_q <= 1'b0;
      angle_upd_q <= 1'b0;
      for (int k = 0; k < PacketLen; k++) begin
        accel_store_q[k] <= '0;
        angle_store_q[k] <= '0;
      end
      for (int k = 0; k < 3; k++) begin
        held_accel_q[k] <= '0;
        held_angle_q[k] <= '0;
      end
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
        in_word_q  <= in_word_i;
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (proc_go && is_byte) begin
        if (pos_q < CapPos) begin
          if (pos_q < AccelEndPos) begin
            accel_store_q[accel_idx] <= in_word_q.rx_byte;
          end
          if (pos_q >= AngleStartPos && pos_q < AngleEndPos) begin
            angle_store_q[angle_idx] <= in_word_q.rx_byte;
          end
          pos_q <= pos_q + 1'b1;
        end
      end

      if (proc_go && is_idle) begin
        pos_q       <= '0;
        out_valid_q <= 1'b1;
        accel_upd_q <= accel_ok;
        angle_upd_q <= angle_ok;
        if (accel_ok) begin
          for (int k = 0; k < 3; k++) begin
            held_accel_q[k] <= {accel_store_q[2 * k + 3], accel_store_q[2 * k + 2]};
          end
        end
        if (angle_ok) begin
          for (int k = 0; k < 3; k++) begin
            held_angle_q[k] <= {angle_store_q[2 * k + 3], angle_store_q[2 * k + 2]};
          end
        end
      end
    end
  end

  // The held values only change when a new result is loaded, which happens only
  // once the previous one has gone, so they serve directly as the output word.
  assign out_valid_o              = out_valid_q;
  assign out_word_o.accel_x       = held_accel_q[0];
  assign out_word_o.accel_y       = held_accel_q[1];
  assign out_word_o.accel_z       = held_accel_q[2];
  assign out_word_o.roll_angle    = held_angle_q[0];
  assign out_word_o.pitch_angle   = held_angle_q[1];
  // A negative yaw plus one full turn is the same word read as unsigned.
  assign out_word_o.yaw_angle     = held_angle_q[2];
  assign out_word_o.accel_updated = accel_upd_q;
  assign out_word_o.angle_updated = angle_upd_q;

endmodule

`default_nettype wire

@@ rtl/ibpd_checker.sv @@
`default_nettype none

module ibpd_checker
  import ibpd_pkg::*;
(
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_o,
  input in_word_t  in_word_i,
  input wire       out_valid_o,
  input wire       out_ready_i,
  input out_word_t out_word_o
);

  // Copy of the last result taken, to check that unflagged values carry over.
  out_word_t last_q;
  logic      seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      seen_q <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      last_q <= out_word_o;
      seen_q <= 1'b1;
    end
  end

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_word_o))
    else $error("result word changed while stalled");

  a_accel_carry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_q && !out_word_o.accel_updated |->
      out_word_o.accel_x == last_q.accel_x && out_word_o.accel_y == last_q.accel_y &&
      out_word_o.accel_z == last_q.accel_z)
    else $error("accelerations changed without an update");

  a_angle_carry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_q && !out_word_o.angle_updated |->
      out_word_o.roll_angle == last_q.roll_angle &&
      out_word_o.pitch_angle == last_q.pitch_angle &&
      out_word_o.yaw_angle == last_q.yaw_angle)
    else $error("angles changed without an update");

endmodule

bind imu_burst_packet_decoder_core ibpd_checker u_ibpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire
